// ----- hw/rtl/tiif_pkg.sv -----
// Package with the byte type and telnet protocol constants of the inbound IAC filter.
`timescale 1ns / 1ps
`default_nettype none
package tiif_pkg;

  typedef logic [7:0] byte_t;

  // Telnet command and option codes
  localparam byte_t IAC_BYTE    = 8'd255;
  localparam byte_t CMD_WILL    = 8'd251;
  localparam byte_t CMD_DO      = 8'd253;
  localparam byte_t OPT_SUPP_GA = 8'd3;

  // Result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Number of results still to deliver, at most three
  typedef logic [1:0] res_cnt_t;

  localparam res_cnt_t CNT_NONE  = 2'd0;
  localparam res_cnt_t CNT_ONE   = 2'd1;
  localparam res_cnt_t CNT_TWO   = 2'd2;
  localparam res_cnt_t CNT_REPLY = 2'd3;

  // Reply byte sent when the given number of reply results remain
  function automatic byte_t reply_byte(input res_cnt_t remaining);
    byte_t b;
    case (remaining)
      CNT_REPLY: b = IAC_BYTE;
      CNT_TWO:   b = CMD_WILL;
      default:   b = OPT_SUPP_GA;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tiif_intf.sv -----
// Handshake channel interfaces of the inbound IAC filter: input, result and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface tiif_in_if;
  import tiif_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  chunk_last;

  modport source (output valid, output rx_byte, output chunk_last, input ready);
  modport sink (input valid, input rx_byte, input chunk_last, output ready);
endinterface

interface tiif_out_if;
  import tiif_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_kind;
  logic  out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_kind, input out_last,
                output ready);
endinterface

interface tiif_cfg_if;
  logic valid;
  logic ready;
  logic binary_mode;

  modport source (output valid, output binary_mode, input ready);
  modport sink (input valid, input binary_mode, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/telnet_inbound_iac_filter.sv -----
// Top level of the telnet inbound IAC filter: input register, parser and result register.
`timescale 1ns / 1ps
`default_nettype none
// The filter takes one received telnet byte per item on in_ch and delivers user data bytes
// (out_kind 0) and reply bytes for the peer (out_kind 1) on out_ch, with out_last marking the
// final result of each input item. A doubled 255 yields one data 255, any other byte after 255
// is a command whose next byte is its option, and DO with option 3 (suppress go-ahead) yields
// the three reply items 255 251 3. Zero data bytes are dropped unless binary_mode, written on
// cfg_ch, is set; an item with chunk_last set abandons any open sequence. Items that give one
// result or none are taken at one per cycle with no gaps while out_ch is ready; each item passes
// the input register and then the result register before its first result is offered on
// out_ch. The result register delivers one result per cycle while out_ch is ready, so an
// item that triggers the three-byte reply holds back the next item until the reply has left.
// The configuration channel is always ready and should only be written while the block is idle.
module telnet_inbound_iac_filter (
  input  wire           clk,
  input  wire           rst_n,
  tiif_in_if.sink       in_ch,
  tiif_out_if.source    out_ch,
  tiif_cfg_if.sink      cfg_ch
);
  import tiif_pkg::*;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_DATA      = 3'b001,
    PH_AFTER_IAC = 3'b010,
    PH_AFTER_CMD = 3'b100
  } phase_t;

  logic     binary_mode_r;

  // Input register
  logic     in_vld_r;
  byte_t    in_byte_r;
  logic     in_last_r;

  // Parser state
  phase_t   phase_r, phase_nxt;
  byte_t    held_cmd_r, held_cmd_nxt;

  // Result register
  res_cnt_t res_cnt_r, res_cnt_nxt;
  byte_t    res_byte_r;
  logic     res_kind_r;

  // Parser outputs for the item in the input register
  res_cnt_t new_cnt;
  byte_t    new_byte;
  logic     new_kind;

  logic     out_fire;
  logic     res_free;
  logic     adv;
  logic     in_ready;

  // The result register can take a new set of results when it is empty or its
  // final result leaves this cycle.
  assign out_fire = out_ch.valid && out_ch.ready;
  assign res_free = (res_cnt_r == CNT_NONE) || ((res_cnt_r == CNT_ONE) && out_ch.ready);
  assign adv      = in_vld_r && res_free;
  assign in_ready = !in_vld_r || adv;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid    = (res_cnt_r != CNT_NONE);
  assign out_ch.out_kind = res_kind_r;
  assign out_ch.out_byte = (res_kind_r == KIND_REPLY) ? reply_byte(res_cnt_r) : res_byte_r;
  assign out_ch.out_last = (res_cnt_r == CNT_ONE);

  // Byte parser: decides the results of one item and the next phase.
  always_comb begin
    new_cnt      = CNT_NONE;
    new_byte     = in_byte_r;
    new_kind     = KIND_DATA;
    phase_nxt    = PH_DATA;
    held_cmd_nxt = held_cmd_r;
    unique case (phase_r)
      PH_AFTER_IAC: begin
        if (in_byte_r == IAC_BYTE) begin
          // Escaped 255 becomes a single data byte
          new_cnt = CNT_ONE;
        end else begin
          held_cmd_nxt = in_byte_r;
          phase_nxt    = PH_AFTER_CMD;
        end
      end
      PH_AFTER_CMD: begin
        if ((held_cmd_r == CMD_DO) && (in_byte_r == OPT_SUPP_GA)) begin
          new_cnt  = CNT_REPLY;
          new_kind = KIND_REPLY;
        end
      end
      default: begin
        if (in_byte_r == IAC_BYTE) begin
          phase_nxt = PH_AFTER_IAC;
        end else if (binary_mode_r || (in_byte_r != 8'd0)) begin
          new_cnt = CNT_ONE;
        end
      end
    endcase
    // A chunk end drops any sequence still open
    if (in_last_r) begin
      phase_nxt = PH_DATA;
    end
  end

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (adv) begin
      res_cnt_nxt = new_cnt;
    end else if (out_fire) begin
      res_cnt_nxt = res_cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r <= 1'b0;
      in_vld_r      <= 1'b0;
      phase_r       <= PH_DATA;
      held_cmd_r    <= 8'd0;
      res_cnt_r     <= CNT_NONE;
    end else begin
      if (cfg_ch.valid) begin
        binary_mode_r <= cfg_ch.binary_mode;
      end
      if (in_ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (adv) begin
        phase_r    <= phase_nxt;
        held_cmd_r <= held_cmd_nxt;
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
      in_last_r <= in_ch.chunk_last;
    end
    if (adv) begin
      res_byte_r <= new_byte;
      res_kind_r <= new_kind;
    end
  end

  // The parser phase stays one-hot.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parser phase is not one-hot");

  // Input is only held back while an item waits behind undelivered results.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_vld_r && (res_cnt_r != CNT_NONE)))
    else $error("input stalled without pending results");

  // After the first reply byte leaves, the rest of the reply is still on offer.
  a_reply_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (res_kind_r == KIND_REPLY) && (res_cnt_r == CNT_REPLY))
    |=> (out_ch.valid && (out_ch.out_byte == CMD_WILL) && !out_ch.out_last))
    else $error("reply sequence broken");

  // An item that ends a chunk leaves the parser in the data phase.
  a_chunk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (phase_r == PH_DATA))
    else $error("open sequence survived a chunk end");

endmodule
`default_nettype wire
